// File: rtl/core/bvai_pkg.sv
package bvai_pkg;

    localparam int unsigned DataW  = 8;
    localparam int unsigned IndexW = 8;
    localparam int unsigned Depth  = 1 << IndexW;
    localparam int unsigned OpW    = 4;

    typedef enum logic [OpW-1:0] {
        OP_INC       = 4'd0,
        OP_DEC       = 4'd1,
        OP_ASN_IMM   = 4'd2,
        OP_ASN_VAR   = 4'd3,
        OP_ADD_IMM   = 4'd4,
        OP_ADD_VAR   = 4'd5,
        OP_SUB_IMM   = 4'd6,
        OP_SUB_VAR   = 4'd7,
        OP_INDL_IMM  = 4'd8,
        OP_INDL_VAR  = 4'd9,
        OP_INDR_LOAD = 4'd10,
        OP_MUL_IMM   = 4'd11,
        OP_MUL_VAR   = 4'd12,
        OP_DIV_IMM   = 4'd13,
        OP_DIV_VAR   = 4'd14
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDA,
        S_RDB,
        S_RDC,
        S_CALC,
        S_DIV,
        S_WR
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DataW-1:0] dividend;
        logic [DataW-1:0] divisor;
    } t_div_req;

endpackage

// File: rtl/core/byte_variable_alu_with_indirection.sv
// flow: an accepted item reads its operands, is evaluated and is written; divides
// also wait on the radix-4 divider; a new item is taken only once the last is written,
// as three serial reads share the single read port of the variable memory
// reset: control state clears at once; the 256 variables read as zero through
// per-entry valid bits until first written, so no clearing pass is needed
module byte_variable_alu_with_indirection (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bvai_pkg::OpW-1:0]    i_operation,
    input  logic [bvai_pkg::IndexW-1:0] i_first_index,
    input  logic [bvai_pkg::DataW-1:0]  i_second_operand,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bvai_pkg::IndexW-1:0] o_written_index,
    output logic [bvai_pkg::DataW-1:0]  o_written_value,
    output logic                        o_divide_by_zero
);
    import bvai_pkg::*;

    t_state              r_state, n_state;
    t_op                 r_op;
    logic [IndexW-1:0]   r_a;
    logic [DataW-1:0]    r_b;
    logic [DataW-1:0]    r_va;
    logic [DataW-1:0]    r_vb;
    logic [IndexW-1:0]   r_target;
    logic [DataW-1:0]    r_val;
    logic                r_write;
    logic                r_dz;

    logic [DataW-1:0]    r_mem [Depth];
    logic [Depth-1:0]    r_vld;
    logic [DataW-1:0]    r_rd_data;
    logic                r_rd_vld;
    logic [IndexW-1:0]   rd_addr;
    logic [DataW-1:0]    rd_val;

    logic                r_out_valid;
    logic [IndexW-1:0]   r_out_idx;
    logic [DataW-1:0]    r_out_val;
    logic                r_out_dz;

    logic                accept;
    logic                wr_fire;
    logic                mem_we;

    logic [IndexW-1:0]   c_target;
    logic [DataW-1:0]    c_val;
    logic                c_write;
    logic                c_dz;
    logic                div_go;
    logic [DataW-1:0]    mul_opnd;
    logic [2*DataW-1:0]  prod;

    t_div_req            div_req;
    logic                div_done;
    logic [DataW-1:0]    div_quo;

    bvai_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign accept  = i_in_valid && (r_state == S_IDLE);
    assign wr_fire = (r_state == S_WR) && (!r_out_valid || !i_out_stall);
    assign mem_we  = wr_fire && r_write;
    assign rd_val  = r_rd_vld ? r_rd_data : '0;

    // variable memory, one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (mem_we) begin
            r_mem[r_target] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[rd_addr];
            if (mem_we) begin
                r_vld[r_target] <= 1'b1;
            end
        end
    end

    // command evaluation, operands are va = v[a], vb = v[b], rd_val = v[v[b]]
    always_comb begin
        mul_opnd = (r_op == OP_MUL_IMM) ? r_b : r_vb;
        prod     = r_va * mul_opnd;
        c_target = r_a;
        c_val    = r_va;
        c_write  = 1'b1;
        c_dz     = 1'b0;
        div_go   = 1'b0;
        case (r_op)
            OP_INC:       c_val = r_va + 1'b1;
            OP_DEC:       c_val = r_va - 1'b1;
            OP_ASN_IMM:   c_val = r_b;
            OP_ASN_VAR:   c_val = r_vb;
            OP_ADD_IMM:   c_val = r_va + r_b;
            OP_ADD_VAR:   c_val = r_va + r_vb;
            OP_SUB_IMM:   c_val = r_va - r_b;
            OP_SUB_VAR:   c_val = r_va - r_vb;
            OP_INDL_IMM: begin
                c_target = r_va;
                c_val    = r_b;
            end
            OP_INDL_VAR: begin
                c_target = r_va;
                c_val    = r_vb;
            end
            OP_INDR_LOAD: c_val = rd_val;
            OP_MUL_IMM,
            OP_MUL_VAR:   c_val = prod[DataW-1:0];
            OP_DIV_IMM: begin
                if (r_b == '0) begin
                    c_dz    = 1'b1;
                    c_write = 1'b0;
                end else begin
                    div_go = 1'b1;
                end
            end
            OP_DIV_VAR: begin
                if (r_vb == '0) begin
                    c_dz    = 1'b1;
                    c_write = 1'b0;
                end else begin
                    div_go = 1'b1;
                end
            end
            default:      c_write = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        rd_addr          = r_a;
        div_req.start    = 1'b0;
        div_req.dividend = r_va;
        div_req.divisor  = (r_op == OP_DIV_IMM) ? r_b : r_vb;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                rd_addr = r_a;
                n_state = S_RDB;
            end
            S_RDB: begin
                rd_addr = r_b;
                n_state = S_RDC;
            end
            S_RDC: begin
                // pointer chase: address is v[b], just returned
                rd_addr = rd_val;
                n_state = S_CALC;
            end
            S_CALC: begin
                div_req.start = div_go;
                n_state       = div_go ? S_DIV : S_WR;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= t_op'(i_operation);
            r_a  <= i_first_index;
            r_b  <= i_second_operand;
        end
        if (r_state == S_RDB) begin
            r_va <= rd_val;
        end
        if (r_state == S_RDC) begin
            r_vb <= rd_val;
        end
        if (r_state == S_CALC) begin
            r_target <= c_target;
            r_val    <= c_val;
            r_write  <= c_write;
            r_dz     <= c_dz;
        end
        if (r_state == S_DIV && div_done) begin
            r_val <= div_quo;
        end
        if (wr_fire) begin
            r_out_idx <= r_target;
            r_out_val <= r_write ? r_val : r_va;
            r_out_dz  <= r_dz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wr_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_written_index  = r_out_idx;
    assign o_written_value  = r_out_val;
    assign o_divide_by_zero = r_out_dz;

    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_RDA))
        else $error("accepted item did not start the operand reads");

    a_div_only_for_div_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_op == OP_DIV_IMM || r_op == OP_DIV_VAR))
        else $error("divider wait entered for a non-divide command");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide wait");

    a_no_write_on_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_fire && r_dz) |-> !mem_we)
        else $error("store written on a divide by zero");

endmodule

// File: rtl/core/bvai_div.sv
module bvai_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bvai_pkg::t_div_req     i_req,
    output logic                   o_done,
    output logic [bvai_pkg::DataW-1:0] o_quotient
);
    import bvai_pkg::*;

    localparam int unsigned StepsPerCycle = 2;
    localparam int unsigned Cycles        = DataW / StepsPerCycle;
    localparam int unsigned CntW          = $clog2(Cycles);

    logic              r_busy;
    logic              r_done;
    logic [CntW-1:0]   r_cnt;
    logic [DataW-1:0]  r_rem;
    logic [DataW-1:0]  r_quo;
    logic [DataW-1:0]  r_dvs;

    logic [DataW-1:0]  rem1, quo1, rem2, quo2;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic logic [2*DataW-1:0] div_step(
        input logic [DataW-1:0] rem,
        input logic [DataW-1:0] quo,
        input logic [DataW-1:0] dvs
    );
        logic [DataW:0] tmp;
        logic           ge;
        logic [DataW:0] diff;
        tmp  = {rem, quo[DataW-1]};
        ge   = (tmp >= {1'b0, dvs});
        diff = tmp - {1'b0, dvs};
        if (ge) begin
            return {diff[DataW-1:0], quo[DataW-2:0], 1'b1};
        end else begin
            return {tmp[DataW-1:0], quo[DataW-2:0], 1'b0};
        end
    endfunction

    always_comb begin
        {rem1, quo1} = div_step(r_rem, r_quo, r_dvs);
        {rem2, quo2} = div_step(rem1, quo1, r_dvs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(Cycles - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= rem2;
            r_quo <= quo2;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
